/* rtl/pee_pkg.sv */
// Shared types, constants and helpers for the postfix expression evaluator.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package pee_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    CC_OTHER,
    CC_DIGIT,
    CC_ADD,
    CC_SUB,
    CC_MUL,
    CC_DIV
  } char_cls_t;

  typedef enum logic [1:0] {
    PS_DIGIT,
    PS_ALU,
    PS_DIV
  } push_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POP_X,
    ST_EXEC,
    ST_DIV,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      push;
    push_sel_t sel;
    logic      pop;
    logic      lat_y;
    logic      div_start;
    logic      set_err;
    logic      clear;
    logic      out_load;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    char_cls_t cls;
    logic      last;
    logic      err;
    logic      y_zero;
    logic      div_done;
    logic      out_free;
  } dp_stat_t;

  function automatic char_cls_t classify(input logic [7:0] c);
    char_cls_t r;
    priority if (c >= CH_ZERO && c <= CH_NINE) r = CC_DIGIT;
    else if (c == CH_PLUS)  r = CC_ADD;
    else if (c == CH_MINUS) r = CC_SUB;
    else if (c == CH_STAR)  r = CC_MUL;
    else if (c == CH_SLASH) r = CC_DIV;
    else                    r = CC_OTHER;
    return r;
  endfunction

endpackage

/* rtl/pee_if.sv */
// Valid/ready channel interfaces for the character input and the result output.
// Depends on pee_pkg for the data width.
interface pee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface pee_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pee_pkg::DATA_W-1:0] value;
  logic                              status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

/* rtl/pee_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pee_pkg for the data width.
module pee_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pee_pkg::DATA_W-1:0] dividend,
  input  logic [pee_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [pee_pkg::DATA_W-1:0] quotient
);

  localparam int STEP_W = $clog2(pee_pkg::DATA_W);

  logic [pee_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [pee_pkg::DATA_W-1:0] quo_r, quo_nxt;
  logic [pee_pkg::DATA_W-1:0] dvs_r;
  logic                       neg_r;
  logic [STEP_W-1:0]          cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [pee_pkg::DATA_W:0]   rem_sh;
  logic [pee_pkg::DATA_W:0]   trial;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    rem_sh = {rem_r, quo_r[pee_pkg::DATA_W-1]};
    trial  = rem_sh - {1'b0, dvs_r};
    if (!trial[pee_pkg::DATA_W]) begin
      rem_nxt = trial[pee_pkg::DATA_W-1:0];
      quo_nxt = {quo_r[pee_pkg::DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[pee_pkg::DATA_W-1:0];
      quo_nxt = {quo_r[pee_pkg::DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(pee_pkg::DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[pee_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs_r <= divisor[pee_pkg::DATA_W-1] ? (~divisor + 1'b1) : divisor;
      neg_r <= dividend[pee_pkg::DATA_W-1] ^ divisor[pee_pkg::DATA_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

/* rtl/pee_dp.sv */
// Datapath: operand stack memory, ALU, divider, error flag and result register.
// Depends on pee_pkg and pee_div.
module pee_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pee_pkg::dp_cmd_t                 cmd,
  output pee_pkg::dp_stat_t                stat,
  input  logic [7:0]                       in_ch,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [pee_pkg::DATA_W-1:0] out_value,
  output logic                             out_status
);

  logic [pee_pkg::DATA_W-1:0] mem [pee_pkg::STACK_DEPTH];

  logic [7:0]                 ch_r;
  logic                       last_r;
  logic [pee_pkg::CNT_W-1:0]  cnt_r;
  logic                       err_r;
  logic [pee_pkg::DATA_W-1:0] rdata_r;
  logic                       pop_hit_r;
  logic [pee_pkg::DATA_W-1:0] y_r;
  logic                       out_valid_r;
  logic [pee_pkg::DATA_W-1:0] out_value_r;
  logic                       out_status_r;

  pee_pkg::char_cls_t         cls;
  logic [pee_pkg::DATA_W-1:0] pop_val;
  logic [pee_pkg::DATA_W-1:0] alu_val;
  logic [pee_pkg::DATA_W-1:0] push_val;
  logic [pee_pkg::DATA_W-1:0] quotient;
  logic [7:0]                 digit;
  logic                       div_done;
  logic                       full;
  logic                       empty;
  logic [pee_pkg::CNT_W-1:0]  cnt_dec;

  assign cls     = pee_pkg::classify(ch_r);
  assign digit   = ch_r - pee_pkg::CH_ZERO;
  assign pop_val = pop_hit_r ? rdata_r : '0;
  assign full    = (cnt_r == pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH));
  assign empty   = (cnt_r == '0);
  assign cnt_dec = cnt_r - 1'b1;

  // The first operand comes straight from the second pop's read data.
  always_comb begin
    unique case (cls)
      pee_pkg::CC_ADD: alu_val = pop_val + y_r;
      pee_pkg::CC_SUB: alu_val = pop_val - y_r;
      pee_pkg::CC_MUL: alu_val = pop_val * y_r;
      default:         alu_val = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.sel)
      pee_pkg::PS_DIGIT: push_val = pee_pkg::DATA_W'(digit);
      pee_pkg::PS_ALU:   push_val = alu_val;
      pee_pkg::PS_DIV:   push_val = quotient;
      default:           push_val = '0;
    endcase
  end

  pee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (pop_val),
    .divisor  (y_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Stack memory: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[cnt_r[pee_pkg::IDX_W-1:0]] <= push_val;
    end
    if (cmd.pop) begin
      rdata_r <= mem[cnt_dec[pee_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      err_r       <= 1'b0;
      pop_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt_r <= '0;
      end else if (cmd.push && !full) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.pop && !empty) begin
        cnt_r <= cnt_dec;
      end
      if (cmd.pop) begin
        pop_hit_r <= !empty;
      end
      if (cmd.clear) begin
        err_r <= 1'b0;
      end else if (cmd.set_err) begin
        err_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r   <= in_ch;
      last_r <= in_last;
    end
    if (cmd.lat_y) begin
      y_r <= pop_val;
    end
    if (cmd.out_load) begin
      out_value_r  <= err_r ? '0 : pop_val;
      out_status_r <= err_r;
    end
  end

  assign stat.cls      = cls;
  assign stat.last     = last_r;
  assign stat.err      = err_r;
  assign stat.y_zero   = (y_r == '0);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

/* rtl/pee_ctrl.sv */
// Controller state machine that sequences each character through the datapath.
// Depends on pee_pkg.
module pee_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output pee_pkg::dp_cmd_t  cmd,
  input  pee_pkg::dp_stat_t stat
);

  pee_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pee_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = pee_pkg::PS_DIGIT;
    in_ready  = 1'b0;
    unique case (state_r)
      pee_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = pee_pkg::ST_DISPATCH;
        end
      end
      pee_pkg::ST_DISPATCH: begin
        if (stat.err || stat.cls == pee_pkg::CC_OTHER) begin
          state_nxt = pee_pkg::ST_FINISH;
        end else if (stat.cls == pee_pkg::CC_DIGIT) begin
          cmd.push  = 1'b1;
          cmd.sel   = pee_pkg::PS_DIGIT;
          state_nxt = pee_pkg::ST_FINISH;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = pee_pkg::ST_POP_X;
        end
      end
      pee_pkg::ST_POP_X: begin
        cmd.lat_y = 1'b1;
        cmd.pop   = 1'b1;
        state_nxt = pee_pkg::ST_EXEC;
      end
      pee_pkg::ST_EXEC: begin
        if (stat.cls == pee_pkg::CC_DIV) begin
          if (stat.y_zero) begin
            cmd.set_err = 1'b1;
            state_nxt   = pee_pkg::ST_FINISH;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = pee_pkg::ST_DIV;
          end
        end else begin
          cmd.push  = 1'b1;
          cmd.sel   = pee_pkg::PS_ALU;
          state_nxt = pee_pkg::ST_FINISH;
        end
      end
      pee_pkg::ST_DIV: begin
        if (stat.div_done) begin
          cmd.push  = 1'b1;
          cmd.sel   = pee_pkg::PS_DIV;
          state_nxt = pee_pkg::ST_FINISH;
        end
      end
      pee_pkg::ST_FINISH: begin
        if (stat.last) begin
          cmd.pop   = 1'b1;
          state_nxt = pee_pkg::ST_EMIT;
        end else begin
          state_nxt = pee_pkg::ST_IDLE;
        end
      end
      pee_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = pee_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pee_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/postfix_expression_evaluator_core.sv */
// Top level of the postfix expression evaluator: controller plus datapath.
// Depends on pee_pkg, pee_if, pee_ctrl, pee_dp and pee_div.
//
// Usage: characters of a postfix expression arrive on in_bus, one beat per
// character, with last set on the final character. Digits push 0..9 onto a
// 32-entry operand stack; + - * / pop two operands and push the result with
// 32-bit wrapping arithmetic, division truncating toward zero. Other
// characters are ignored. A pop from an empty stack gives 0 and a push onto
// a full stack is dropped. Division by zero sets an error and the rest of
// the expression is skipped.
// On the last character one beat leaves on out_bus: the popped top of stack
// with status 0, or value 0 with status 1 after a division by zero. The stack
// and the error are then cleared for the next expression.
// Sequencing: one character is in work at a time. Division runs in the
// shift-subtract divider, which produces one quotient bit per cycle. For
// the last character the FINISH state pops the top of stack, and the EMIT
// state loads that pop into the result register once the register is free.
// The result register holds its beat while out_bus.ready is low; new input
// is still accepted, and only the next result waits for the register to free.
// Reset is synchronous and active low; it empties the stack and clears the
// error and the result valid. No clearing pass is needed.
module postfix_expression_evaluator_core (
  input  logic      clk,
  input  logic      rst_n,
  pee_in_if.sink    in_bus,
  pee_out_if.source out_bus
);

  pee_pkg::dp_cmd_t  cmd;
  pee_pkg::dp_stat_t stat;

  // The sequencer drives the datapath commands from its current state.
  pee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath owns the stack, the arithmetic and the result register.
  pee_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_ch      (in_bus.ch),
    .in_last    (in_bus.last),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_value  (out_bus.value),
    .out_status (out_bus.status)
  );

endmodule

/* rtl/pee_chk.sv */
// Port-level checker for the postfix expression evaluator, and its bind.
// Depends on pee_pkg; attaches to postfix_expression_evaluator_core.
module pee_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [pee_pkg::DATA_W-1:0] out_value,
  input logic                              out_status
);

  // A result beat is held until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // An error result always carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_value == '0)
    else $error("error result with nonzero value");

  // Characters are processed one at a time.
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a character is in work");

  // A character without last never produces a result.
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> !$rose(out_valid))
    else $error("result produced by a character without last");

endmodule

bind postfix_expression_evaluator_core pee_chk u_pee_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .in_last    (in_bus.last),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_value  (out_bus.value),
  .out_status (out_bus.status)
);
